/* hdl/amsee_pkg.sv */
package amsee_pkg;

    localparam int DATA_W            = 32;
    localparam int NORM_W            = 32;
    localparam int ANG_W             = 16;
    localparam int XY_W              = 34;
    localparam int Z_W               = 24;
    localparam int CORDIC_STEPS      = 21;
    localparam int CORDIC_LAT        = CORDIC_STEPS + 2;
    localparam int EPS_BITS          = 23;
    localparam int ANG_SHIFT         = 7;
    localparam int SUM_W             = 64;
    localparam int COS_SQ_W          = 62;
    localparam int SCALE_ROOT_STAGES = SUM_W / 2;
    localparam int COS_ROOT_STAGES   = COS_SQ_W / 2;
    localparam int DIV_STAGES        = 31;
    localparam int ANGLE_MAX         = 32767;

    localparam logic signed [Z_W-1:0] HALF_PI_A = 24'sd1647099;
    localparam logic [30:0]           ONE_Q30   = 31'h4000_0000;

    typedef logic signed [DATA_W-1:0] elem_t;
    typedef logic [DATA_W-1:0]        umag_t;
    typedef logic signed [NORM_W-1:0] norm_t;
    typedef logic signed [ANG_W-1:0]  angle_t;

    typedef struct packed {
        elem_t c0_x;
        elem_t c0_y;
        elem_t c0_z;
        elem_t c1_x;
        elem_t c1_y;
        elem_t c1_z;
        elem_t c2_x;
        elem_t c2_y;
        elem_t c2_z;
        elem_t corner_w;
    } matrix_t;

    // Elementary angles atan(2^-i) in units of 2^-20 rad.
    function automatic logic signed [Z_W-1:0] atan_entry(input int idx);
        logic signed [Z_W-1:0] val;
        case (idx)
            0:       val = 24'sd823550;
            1:       val = 24'sd486170;
            2:       val = 24'sd256879;
            3:       val = 24'sd130396;
            4:       val = 24'sd65451;
            5:       val = 24'sd32757;
            6:       val = 24'sd16383;
            7:       val = 24'sd8192;
            8:       val = 24'sd4096;
            9:       val = 24'sd2048;
            10:      val = 24'sd1024;
            11:      val = 24'sd512;
            12:      val = 24'sd256;
            13:      val = 24'sd128;
            14:      val = 24'sd64;
            15:      val = 24'sd32;
            16:      val = 24'sd16;
            17:      val = 24'sd8;
            18:      val = 24'sd4;
            19:      val = 24'sd2;
            20:      val = 24'sd1;
            default: val = '0;
        endcase
        return val;
    endfunction

    function automatic umag_t mag32(input elem_t v);
        elem_t neg;
        neg = -v;
        return v[DATA_W-1] ? umag_t'(neg) : umag_t'(v);
    endfunction

endpackage

/* hdl/amsee_in_if.sv */
interface amsee_in_if;
    import amsee_pkg::*;

    logic  valid;
    logic  ready;
    elem_t c0_x;
    elem_t c0_y;
    elem_t c0_z;
    elem_t c1_x;
    elem_t c1_y;
    elem_t c1_z;
    elem_t c2_x;
    elem_t c2_y;
    elem_t c2_z;
    elem_t corner_w;

    modport source (
        output valid, c0_x, c0_y, c0_z, c1_x, c1_y, c1_z, c2_x, c2_y, c2_z, corner_w,
        input  ready
    );
    modport sink (
        input  valid, c0_x, c0_y, c0_z, c1_x, c1_y, c1_z, c2_x, c2_y, c2_z, corner_w,
        output ready
    );
endinterface

/* hdl/amsee_out_if.sv */
interface amsee_out_if;
    import amsee_pkg::*;

    logic   valid;
    logic   ready;
    umag_t  scale_x;
    umag_t  scale_y;
    umag_t  scale_z;
    angle_t angle_x;
    angle_t angle_y;
    angle_t angle_z;
    logic   ok;

    modport source (
        output valid, scale_x, scale_y, scale_z, angle_x, angle_y, angle_z, ok,
        input  ready
    );
    modport sink (
        input  valid, scale_x, scale_y, scale_z, angle_x, angle_y, angle_z, ok,
        output ready
    );
endinterface

/* hdl/amsee_delay.sv */
module amsee_delay #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             en,
    input  logic [WIDTH-1:0] d,
    output logic [WIDTH-1:0] q
);
    logic [WIDTH-1:0] tap_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tap_reg[0] <= d;
            for (int i = 1; i < DEPTH; i++)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign q = tap_reg[DEPTH-1];
endmodule

/* hdl/amsee_isqrt.sv */
module amsee_isqrt #(
    parameter int IN_W = 64
) (
    input  logic                clk,
    input  logic                en,
    input  logic [IN_W-1:0]     value,
    output logic [IN_W/2-1:0]   root
);
    localparam int OUT_W = IN_W / 2;

    logic [OUT_W:0]   rem_reg  [OUT_W];
    logic [OUT_W-1:0] root_reg [OUT_W];
    logic [IN_W-1:0]  val_reg  [OUT_W];

    // One result bit per stage, most significant first.
    for (genvar i = 0; i < OUT_W; i++)
    begin : g_stage
        localparam int P = OUT_W - 1 - i;
        logic [OUT_W:0]   rem_in;
        logic [OUT_W-1:0] root_in;
        logic [IN_W-1:0]  val_in;
        logic [OUT_W+2:0] trial_rem;
        logic [OUT_W+2:0] trial_sub;
        logic [OUT_W+2:0] diff;

        if (i == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign val_in  = value;
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[i-1];
            assign root_in = root_reg[i-1];
            assign val_in  = val_reg[i-1];
        end

        assign trial_rem = {rem_in, val_in[2*P+1 -: 2]};
        assign trial_sub = {1'b0, root_in, 2'b01};
        assign diff      = trial_rem - trial_sub;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                val_reg[i] <= val_in;
                if (trial_rem >= trial_sub)
                begin
                    rem_reg[i]  <= diff[OUT_W:0];
                    root_reg[i] <= {root_in[OUT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[i]  <= trial_rem[OUT_W:0];
                    root_reg[i] <= {root_in[OUT_W-2:0], 1'b0};
                end
            end
        end
    end

    assign root = root_reg[OUT_W-1];
endmodule

/* hdl/amsee_div.sv */
module amsee_div (
    input  logic            clk,
    input  logic            en,
    input  amsee_pkg::umag_t num,
    input  amsee_pkg::umag_t den,
    input  logic            neg,
    output amsee_pkg::norm_t quo
);
    import amsee_pkg::*;

    logic [DATA_W-1:0]     rem_reg [DIV_STAGES];
    logic [DATA_W-1:0]     den_reg [DIV_STAGES];
    logic [DIV_STAGES-1:0] quo_reg [DIV_STAGES];
    logic                  neg_reg [DIV_STAGES];

    // Restoring division of num * 2^30 by den; num never exceeds den, so the
    // quotient has 31 bits and the first stage takes num as it is.
    for (genvar j = 0; j < DIV_STAGES; j++)
    begin : g_stage
        logic [DATA_W-1:0]     rem_in;
        logic [DATA_W-1:0]     den_in;
        logic [DIV_STAGES-1:0] quo_in;
        logic                  neg_in;
        logic [DATA_W:0]       trial;
        logic [DATA_W:0]       diff;

        if (j == 0)
        begin : g_first
            assign rem_in = num;
            assign den_in = den;
            assign quo_in = '0;
            assign neg_in = neg;
            assign trial  = {1'b0, rem_in};
        end
        else
        begin : g_next
            assign rem_in = rem_reg[j-1];
            assign den_in = den_reg[j-1];
            assign quo_in = quo_reg[j-1];
            assign neg_in = neg_reg[j-1];
            assign trial  = {rem_in, 1'b0};
        end

        assign diff = trial - {1'b0, den_in};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                den_reg[j] <= den_in;
                neg_reg[j] <= neg_in;
                if (trial >= {1'b0, den_in})
                begin
                    rem_reg[j] <= diff[DATA_W-1:0];
                    quo_reg[j] <= {quo_in[DIV_STAGES-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[j] <= trial[DATA_W-1:0];
                    quo_reg[j] <= {quo_in[DIV_STAGES-2:0], 1'b0};
                end
            end
        end
    end

    norm_t quo_pos;
    assign quo_pos = norm_t'({1'b0, quo_reg[DIV_STAGES-1]});
    assign quo     = neg_reg[DIV_STAGES-1] ? -quo_pos : quo_pos;
endmodule

/* hdl/amsee_cordic.sv */
module amsee_cordic (
    input  logic             clk,
    input  logic             en,
    input  amsee_pkg::norm_t y_in,
    input  amsee_pkg::norm_t x_in,
    output amsee_pkg::angle_t angle
);
    import amsee_pkg::*;

    function automatic logic signed [XY_W-1:0] shr_tz(input logic signed [XY_W-1:0] v,
                                                      input int s);
        logic signed [XY_W-1:0] m;
        m = v[XY_W-1] ? -v : v;
        m = m >> s;
        return v[XY_W-1] ? -m : m;
    endfunction

    logic signed [XY_W-1:0] x_reg [CORDIC_STEPS+1];
    logic signed [XY_W-1:0] y_reg [CORDIC_STEPS+1];
    logic signed [Z_W-1:0]  z_reg [CORDIC_STEPS+1];
    logic                   zero_reg [CORDIC_STEPS+1];
    angle_t                 angle_reg;

    logic signed [XY_W-1:0] xe;
    logic signed [XY_W-1:0] ye;
    logic signed [XY_W-1:0] x_pre;
    logic signed [XY_W-1:0] y_pre;
    logic signed [Z_W-1:0]  z_pre;

    assign xe = {{(XY_W-NORM_W){x_in[NORM_W-1]}}, x_in};
    assign ye = {{(XY_W-NORM_W){y_in[NORM_W-1]}}, y_in};

    // A vector in the left half plane is first turned by a quarter turn.
    always_comb
    begin
        x_pre = xe;
        y_pre = ye;
        z_pre = '0;
        if (x_in[NORM_W-1])
        begin
            if (!y_in[NORM_W-1])
            begin
                x_pre = ye;
                y_pre = -xe;
                z_pre = HALF_PI_A;
            end
            else
            begin
                x_pre = -ye;
                y_pre = xe;
                z_pre = -HALF_PI_A;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= x_pre;
            y_reg[0]    <= y_pre;
            z_reg[0]    <= z_pre;
            zero_reg[0] <= (x_in == '0) && (y_in == '0);
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_iter
        logic signed [XY_W-1:0] xs;
        logic signed [XY_W-1:0] ys;

        assign xs = shr_tz(x_reg[i], i);
        assign ys = shr_tz(y_reg[i], i);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                zero_reg[i+1] <= zero_reg[i];
                if (!y_reg[i][XY_W-1])
                begin
                    x_reg[i+1] <= x_reg[i] + ys;
                    y_reg[i+1] <= y_reg[i] - xs;
                    z_reg[i+1] <= z_reg[i] + atan_entry(i);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - ys;
                    y_reg[i+1] <= y_reg[i] + xs;
                    z_reg[i+1] <= z_reg[i] - atan_entry(i);
                end
            end
        end
    end

    logic signed [Z_W-1:0] z_fin;
    logic [Z_W-1:0]        z_abs;
    logic [Z_W-1:0]        z_rnd;
    logic [ANG_W-1:0]      m_sat;

    assign z_fin = z_reg[CORDIC_STEPS];
    assign z_abs = z_fin[Z_W-1] ? Z_W'(-z_fin) : Z_W'(z_fin);
    assign z_rnd = (z_abs + Z_W'(1 << (ANG_SHIFT - 1))) >> ANG_SHIFT;
    assign m_sat = (z_rnd > Z_W'(ANGLE_MAX)) ? ANG_W'(ANGLE_MAX) : z_rnd[ANG_W-1:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (zero_reg[CORDIC_STEPS])
            begin
                angle_reg <= '0;
            end
            else if (z_fin[Z_W-1])
            begin
                angle_reg <= -angle_t'(m_sat);
            end
            else
            begin
                angle_reg <= angle_t'(m_sat);
            end
        end
    end

    assign angle = angle_reg;
endmodule

/* hdl/affine_matrix_scale_euler_extract_core.sv */
// Scale and XYZ Euler angle extraction from the 3x3 part of an affine transform.
//
// The matrix channel carries one column-major 3x3 matrix and its homogeneous
// corner element per transaction; the result channel returns the three column
// lengths, the three angles in Q2.13 radians and an ok flag, with all result
// fields zero when ok is low. Both channels use valid/ready handshakes.
//
// An accepted matrix passes through squaring and summing, the column-length
// roots, the seven divider lanes, the cosine squaring and square root and the
// three CORDIC lanes. The core takes one matrix per cycle while the receiver
// does not stall; every unit is fully pipelined.
//
// Reset clears the stage valid bits and the skid register's valid flag, so the
// pipeline comes up empty. When the receiver stalls, the whole pipeline holds
// and the result stays on the port; one more matrix is taken into the skid
// register, after which ready drops until the result is taken.
module affine_matrix_scale_euler_extract_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    amsee_in_if.sink     matrix,
    amsee_out_if.source  result
);
    import amsee_pkg::*;

    localparam int TOTAL_LAT  = 2 + SCALE_ROOT_STAGES + DIV_STAGES + 1 + COS_ROOT_STAGES
                                + CORDIC_LAT;
    localparam int SCALE_DLY  = DIV_STAGES + 1 + COS_ROOT_STAGES + CORDIC_LAT;
    localparam int OK_DLY     = SCALE_ROOT_STAGES + SCALE_DLY;
    localparam int NORM_DLY   = 1 + COS_ROOT_STAGES;
    localparam int N_KEEP     = 7;
    localparam int KEEP_SRC [N_KEEP] = '{0, 1, 2, 4, 5, 6, 8};
    localparam int KEEP_COL [N_KEEP] = '{0, 0, 0, 1, 1, 2, 2};
    localparam umag_t CORNER_THR = (FRAC_BITS > EPS_BITS)
                                   ? (umag_t'(1) << (FRAC_BITS - EPS_BITS)) : umag_t'(1);

    logic en;
    assign en = !result.valid || result.ready;

    // Input skid register.
    matrix_t in_item;
    matrix_t skid_reg;
    matrix_t pipe_in;
    logic    skid_valid_reg;
    logic    pipe_valid;

    assign in_item = {matrix.c0_x, matrix.c0_y, matrix.c0_z,
                      matrix.c1_x, matrix.c1_y, matrix.c1_z,
                      matrix.c2_x, matrix.c2_y, matrix.c2_z, matrix.corner_w};
    assign matrix.ready = !skid_valid_reg;
    assign pipe_in      = skid_valid_reg ? skid_reg : in_item;
    assign pipe_valid   = skid_valid_reg || matrix.valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            skid_valid_reg <= 1'b0;
        end
        else if (matrix.valid && !skid_valid_reg)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!en && matrix.valid && !skid_valid_reg)
        begin
            skid_reg <= in_item;
        end
    end

    logic [TOTAL_LAT-1:0] valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[TOTAL_LAT-2:0], pipe_valid};
        end
    end

    // Stage A: squares of the element magnitudes.
    elem_t            in_e [9];
    logic [SUM_W-1:0] sq_a_reg [9];
    elem_t            keep_a_reg [N_KEEP];
    logic             ok_a_reg;

    assign in_e[0] = pipe_in.c0_x;
    assign in_e[1] = pipe_in.c0_y;
    assign in_e[2] = pipe_in.c0_z;
    assign in_e[3] = pipe_in.c1_x;
    assign in_e[4] = pipe_in.c1_y;
    assign in_e[5] = pipe_in.c1_z;
    assign in_e[6] = pipe_in.c2_x;
    assign in_e[7] = pipe_in.c2_y;
    assign in_e[8] = pipe_in.c2_z;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 9; i++)
            begin
                sq_a_reg[i] <= SUM_W'(mag32(in_e[i])) * SUM_W'(mag32(in_e[i]));
            end
            for (int k = 0; k < N_KEEP; k++)
            begin
                keep_a_reg[k] <= in_e[KEEP_SRC[k]];
            end
            ok_a_reg <= mag32(pipe_in.corner_w) >= CORNER_THR;
        end
    end

    // Stage B: squared column lengths.
    logic [SUM_W-1:0] sum_b_reg [3];
    elem_t            keep_b_reg [N_KEEP];
    logic             ok_b_reg;
    logic [SUM_W-1:0] sum_b [3];

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            sum_b[c] = sq_a_reg[3*c] + sq_a_reg[3*c+1] + sq_a_reg[3*c+2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_b_reg  <= sum_b;
            keep_b_reg <= keep_a_reg;
            ok_b_reg   <= ok_a_reg && (sum_b[0] != '0) && (sum_b[1] != '0)
                          && (sum_b[2] != '0);
        end
    end

    // Column lengths.
    umag_t len [3];

    for (genvar c = 0; c < 3; c++)
    begin : g_len
        amsee_isqrt #(
            .IN_W (SUM_W)
        ) u_len_root (
            .clk   (clk),
            .en    (en),
            .value (sum_b_reg[c]),
            .root  (len[c])
        );
    end

    // Normalization lanes.
    norm_t n_div [N_KEEP];
    norm_t n_dly [N_KEEP];

    for (genvar k = 0; k < N_KEEP; k++)
    begin : g_norm
        elem_t e_dly;

        amsee_delay #(
            .WIDTH (DATA_W),
            .DEPTH (SCALE_ROOT_STAGES)
        ) u_elem_dly (
            .clk (clk),
            .en  (en),
            .d   (keep_b_reg[k]),
            .q   (e_dly)
        );

        amsee_div u_div (
            .clk (clk),
            .en  (en),
            .num (mag32(e_dly)),
            .den (len[KEEP_COL[k]]),
            .neg (e_dly[DATA_W-1]),
            .quo (n_div[k])
        );

        amsee_delay #(
            .WIDTH (NORM_W),
            .DEPTH (NORM_DLY)
        ) u_norm_dly (
            .clk (clk),
            .en  (en),
            .d   (n_div[k]),
            .q   (n_dly[k])
        );
    end

    // Cosine of angle_y from the normalized z element of column 0.
    logic [30:0]         n0z_mag;
    logic [COS_SQ_W-1:0] cos_sq_reg;
    logic [COS_SQ_W-1:0] cos_arg;
    logic [30:0]         cos_y;
    logic                gimbal;
    logic                gimbal_dly;

    assign n0z_mag = n_div[2][NORM_W-1] ? 31'(-n_div[2]) : 31'(n_div[2]);
    assign gimbal  = n0z_mag == ONE_Q30;
    assign cos_arg = (COS_SQ_W'(1) << 60) - cos_sq_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_sq_reg <= COS_SQ_W'(n0z_mag) * COS_SQ_W'(n0z_mag);
        end
    end

    amsee_isqrt #(
        .IN_W (COS_SQ_W)
    ) u_cos_root (
        .clk   (clk),
        .en    (en),
        .value (cos_arg),
        .root  (cos_y)
    );

    amsee_delay #(
        .WIDTH (1),
        .DEPTH (NORM_DLY)
    ) u_gimbal_dly (
        .clk (clk),
        .en  (en),
        .d   (gimbal),
        .q   (gimbal_dly)
    );

    // Angle lanes. Kept order: n0x n0y n0z n1y n1z n2x n2z.
    norm_t  ax_y;
    norm_t  ax_x;
    norm_t  az_y;
    norm_t  az_x;
    angle_t ang_x;
    angle_t ang_y;
    angle_t ang_z;

    assign ax_y = gimbal_dly ? -n_dly[5] : n_dly[4];
    assign ax_x = gimbal_dly ? n_dly[3]  : n_dly[6];
    assign az_y = gimbal_dly ? norm_t'(0) : n_dly[1];
    assign az_x = gimbal_dly ? norm_t'(0) : n_dly[0];

    amsee_cordic u_cordic_x (
        .clk   (clk),
        .en    (en),
        .y_in  (ax_y),
        .x_in  (ax_x),
        .angle (ang_x)
    );

    amsee_cordic u_cordic_y (
        .clk   (clk),
        .en    (en),
        .y_in  (-n_dly[2]),
        .x_in  (norm_t'({1'b0, cos_y})),
        .angle (ang_y)
    );

    amsee_cordic u_cordic_z (
        .clk   (clk),
        .en    (en),
        .y_in  (az_y),
        .x_in  (az_x),
        .angle (ang_z)
    );

    // Scales and ok flag travel alongside.
    logic [3*DATA_W-1:0] scale_dly;
    logic                ok_dly;

    amsee_delay #(
        .WIDTH (3*DATA_W),
        .DEPTH (SCALE_DLY)
    ) u_scale_dly (
        .clk (clk),
        .en  (en),
        .d   ({len[0], len[1], len[2]}),
        .q   (scale_dly)
    );

    amsee_delay #(
        .WIDTH (1),
        .DEPTH (OK_DLY)
    ) u_ok_dly (
        .clk (clk),
        .en  (en),
        .d   (ok_b_reg),
        .q   (ok_dly)
    );

    assign result.valid   = valid_reg[TOTAL_LAT-1];
    assign result.ok      = ok_dly;
    assign result.scale_x = ok_dly ? scale_dly[3*DATA_W-1:2*DATA_W] : '0;
    assign result.scale_y = ok_dly ? scale_dly[2*DATA_W-1:DATA_W]   : '0;
    assign result.scale_z = ok_dly ? scale_dly[DATA_W-1:0]          : '0;
    assign result.angle_x = ok_dly ? ang_x : '0;
    assign result.angle_y = ok_dly ? ang_y : '0;
    assign result.angle_z = ok_dly ? ang_z : '0;

`ifndef ASSERT_OFF
    a_skid_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (!en && skid_valid_reg) |=> skid_valid_reg)
        else $error("skid transaction lost during stall");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.ready) |=>
        (result.valid && $stable(result.scale_x) && $stable(result.angle_y)))
        else $error("pipeline moved while result stalled");

    a_ok_scales: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.ok) |->
        (result.scale_x != '0 && result.scale_y != '0 && result.scale_z != '0))
        else $error("valid result with zero column length");

    a_angle_y_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.angle_y <= 16'sd12900 && result.angle_y >= -16'sd12900))
        else $error("angle_y outside half turn");
`endif
endmodule
